FILE: rtl/core/bpsd_pkg.sv
// Shared types, constants and microprogram for the backlight pulse-step dimmer.
package bpsd_pkg;

	localparam int unsigned LVL_W  = 6;
	localparam int unsigned TICK_W = 10;
	localparam int unsigned REQ_W  = 8;
	localparam int unsigned UPC_W  = 4;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [LVL_W-1:0] RESTART_LEVEL = 6'd16;
	localparam logic [LVL_W-1:0] RESET_LEVEL   = 6'd6;

	localparam logic [TICK_W-1:0] UP_LOW_RST      = 10'd10;
	localparam logic [TICK_W-1:0] DOWN_LOW_RST    = 10'd200;
	localparam logic [TICK_W-1:0] GAP_RST         = 10'd3;
	localparam logic [TICK_W-1:0] OFF_HOLD_RST    = 10'd800;
	localparam logic [TICK_W-1:0] ENABLE_HOLD_RST = 10'd5;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_UP_LOW      = 3'd0;
	localparam logic [2:0] REG_DOWN_LOW    = 3'd1;
	localparam logic [2:0] REG_GAP         = 3'd2;
	localparam logic [2:0] REG_OFF_HOLD    = 3'd3;
	localparam logic [2:0] REG_ENABLE_HOLD = 3'd4;

	// pin actions
	localparam logic [1:0] ACT_LOW      = 2'd0;
	localparam logic [1:0] ACT_OFF_HOLD = 2'd1;
	localparam logic [1:0] ACT_ENABLE   = 2'd2;
	localparam logic [1:0] ACT_STEP     = 2'd3;

	// jump conditions
	localparam logic [2:0] COND_NEVER    = 3'd0;
	localparam logic [2:0] COND_ALWAYS   = 3'd1;
	localparam logic [2:0] COND_NO_INPUT = 3'd2;
	localparam logic [2:0] COND_PWR_OFF  = 3'd3;
	localparam logic [2:0] COND_REQ_ZERO = 3'd4;
	localparam logic [2:0] COND_CUR_NZ   = 3'd5;
	localparam logic [2:0] COND_REQ_EQ   = 3'd6;
	localparam logic [2:0] COND_MORE     = 3'd7;

	// level register operations
	localparam logic [1:0] LVL_HOLD    = 2'd0;
	localparam logic [1:0] LVL_RESTART = 2'd1;
	localparam logic [1:0] LVL_REQ     = 2'd2;
	localparam logic [1:0] LVL_ZERO    = 2'd3;

	// microprogram addresses
	localparam logic [UPC_W-1:0] UA_WAIT   = 4'd0;
	localparam logic [UPC_W-1:0] UA_PWR    = 4'd1;
	localparam logic [UPC_W-1:0] UA_ZERO   = 4'd2;
	localparam logic [UPC_W-1:0] UA_CURCHK = 4'd3;
	localparam logic [UPC_W-1:0] UA_ENABLE = 4'd4;
	localparam logic [UPC_W-1:0] UA_CMP    = 4'd5;
	localparam logic [UPC_W-1:0] UA_STEP   = 4'd6;
	localparam logic [UPC_W-1:0] UA_STORE  = 4'd7;
	localparam logic [UPC_W-1:0] UA_PWROFF = 4'd8;
	localparam logic [UPC_W-1:0] UA_OFF    = 4'd9;
	localparam logic [UPC_W-1:0] UA_LAST   = UA_OFF;

	typedef struct packed {
		logic              take_input;
		logic              emit;
		logic [1:0]        action;
		logic [2:0]        cond;
		logic [UPC_W-1:0]  target;
		logic [1:0]        lvl_op;
		logic              load_cnt;
	} ucode_t;

	typedef struct packed {
		logic   go;
		ucode_t uw;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic pwr_off;
		logic req_zero;
		logic cur_nz;
		logic req_eq;
		logic more;
		logic slot_free;
	} status_t;

	typedef struct packed {
		logic [TICK_W-1:0] up_low;
		logic [TICK_W-1:0] down_low;
		logic [TICK_W-1:0] gap;
		logic [TICK_W-1:0] off_hold;
		logic [TICK_W-1:0] enable_hold;
	} cfg_t;

	function automatic ucode_t uc(input logic take, input logic emit, input logic [1:0] act,
			input logic [2:0] cond, input logic [UPC_W-1:0] tgt, input logic [1:0] lop,
			input logic ldc);
		ucode_t w;
		w.take_input = take;
		w.emit       = emit;
		w.action     = act;
		w.cond       = cond;
		w.target     = tgt;
		w.lvl_op     = lop;
		w.load_cnt   = ldc;
		return w;
	endfunction

	// control store: false condition falls through to the next address
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucode_t w;
		case (upc)
			UA_WAIT:   w = uc(1'b1, 1'b0, ACT_LOW, COND_NO_INPUT, UA_WAIT, LVL_HOLD, 1'b0);
			UA_PWR:    w = uc(1'b0, 1'b0, ACT_LOW, COND_PWR_OFF, UA_PWROFF, LVL_HOLD, 1'b0);
			UA_ZERO:   w = uc(1'b0, 1'b0, ACT_LOW, COND_REQ_ZERO, UA_OFF, LVL_HOLD, 1'b0);
			UA_CURCHK: w = uc(1'b0, 1'b0, ACT_LOW, COND_CUR_NZ, UA_CMP, LVL_HOLD, 1'b0);
			UA_ENABLE: w = uc(1'b0, 1'b1, ACT_ENABLE, COND_NEVER, UA_WAIT, LVL_RESTART, 1'b0);
			UA_CMP:    w = uc(1'b0, 1'b0, ACT_LOW, COND_REQ_EQ, UA_WAIT, LVL_HOLD, 1'b1);
			UA_STEP:   w = uc(1'b0, 1'b1, ACT_STEP, COND_MORE, UA_STEP, LVL_HOLD, 1'b0);
			UA_STORE:  w = uc(1'b0, 1'b0, ACT_LOW, COND_ALWAYS, UA_WAIT, LVL_REQ, 1'b0);
			UA_PWROFF: w = uc(1'b0, 1'b1, ACT_LOW, COND_ALWAYS, UA_WAIT, LVL_HOLD, 1'b0);
			UA_OFF:    w = uc(1'b0, 1'b1, ACT_OFF_HOLD, COND_ALWAYS, UA_WAIT, LVL_ZERO, 1'b0);
			default:   w = uc(1'b0, 1'b0, ACT_LOW, COND_ALWAYS, UA_WAIT, LVL_HOLD, 1'b0);
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/bpsd_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module bpsd_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  bpsd_pkg::status_t st,
	output bpsd_pkg::ctrl_t   ctrl
);

	logic [bpsd_pkg::UPC_W-1:0] upc_q;
	logic [bpsd_pkg::UPC_W-1:0] upc_nxt;
	bpsd_pkg::ucode_t           uw;
	logic                       go;
	logic                       taken;

	assign uw = bpsd_pkg::ucode_rom(upc_q);

	// stall an emitting step until the output register has room
	assign go = !(uw.emit && !st.slot_free);

	always_comb begin
		case (uw.cond)
			bpsd_pkg::COND_NEVER:    taken = 1'b0;
			bpsd_pkg::COND_ALWAYS:   taken = 1'b1;
			bpsd_pkg::COND_NO_INPUT: taken = !st.in_fire;
			bpsd_pkg::COND_PWR_OFF:  taken = st.pwr_off;
			bpsd_pkg::COND_REQ_ZERO: taken = st.req_zero;
			bpsd_pkg::COND_CUR_NZ:   taken = st.cur_nz;
			bpsd_pkg::COND_REQ_EQ:   taken = st.req_eq;
			bpsd_pkg::COND_MORE:     taken = st.more;
			default:                 taken = 1'b0;
		endcase
	end

	always_comb begin
		if (!go) begin
			upc_nxt = upc_q;
		end else if (taken) begin
			upc_nxt = uw.target;
		end else begin
			upc_nxt = upc_q + bpsd_pkg::UPC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= bpsd_pkg::UA_WAIT;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	assign ctrl.go = go;
	assign ctrl.uw = uw;

	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= bpsd_pkg::UA_LAST)
		else $error("microprogram counter out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.emit && !st.slot_free) |=> (upc_q == $past(upc_q)))
		else $error("sequencer advanced over a stalled emit");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		st.in_fire |=> (upc_q == bpsd_pkg::UA_PWR))
		else $error("accepted word not dispatched");

endmodule

FILE: rtl/core/bpsd_dpath.sv
// Datapath: request latch, level and step count registers, event build, output register.
module bpsd_dpath #(
	parameter int unsigned MAX_LEVEL = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic [bpsd_pkg::REQ_W-1:0]   s_tdata,
	input  logic                         s_tuser,
	input  bpsd_pkg::ctrl_t              ctrl,
	input  bpsd_pkg::cfg_t               cfg,
	output bpsd_pkg::status_t            st,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,
	output logic [2:0]                   m_tuser,
	output logic                         m_tlast
);

	localparam logic [bpsd_pkg::LVL_W-1:0] MAX_LVL = bpsd_pkg::LVL_W'(MAX_LEVEL);
	localparam int unsigned LVL_CEIL = (MAX_LEVEL > 16) ? MAX_LEVEL : 16;

	logic [bpsd_pkg::LVL_W-1:0]  req_q;
	logic                        pwr_q;
	logic [bpsd_pkg::LVL_W-1:0]  cur_q;
	logic [bpsd_pkg::LVL_W-1:0]  cnt_q;
	logic                        down_q;
	logic                        in_fire;
	logic                        fire;
	logic [bpsd_pkg::LVL_W-1:0]  req_sat;
	logic                        req_lt;

	logic                        out_valid_q;
	logic [1:0]                  act_q;
	logic                        sdown_q;
	logic [bpsd_pkg::TICK_W-1:0] low_q;
	logic [bpsd_pkg::TICK_W-1:0] high_q;
	logic                        last_q;

	logic                        ev_down;
	logic [bpsd_pkg::TICK_W-1:0] ev_low;
	logic [bpsd_pkg::TICK_W-1:0] ev_high;
	logic                        ev_last;

	assign in_fire = s_tvalid && ctrl.uw.take_input;
	assign fire    = ctrl.go;
	assign req_sat = (s_tdata > bpsd_pkg::REQ_W'(MAX_LEVEL)) ? MAX_LVL
		: s_tdata[bpsd_pkg::LVL_W-1:0];
	assign req_lt  = req_q < cur_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= req_sat;
			pwr_q <= s_tuser;
		end
		if (fire && ctrl.uw.load_cnt) begin
			cnt_q  <= req_lt ? (cur_q - req_q) : (req_q - cur_q);
			down_q <= req_lt;
		end else if (fire && ctrl.uw.emit && ctrl.uw.action == bpsd_pkg::ACT_STEP) begin
			cnt_q <= cnt_q - bpsd_pkg::LVL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= bpsd_pkg::RESET_LEVEL;
		end else if (fire) begin
			case (ctrl.uw.lvl_op)
				bpsd_pkg::LVL_HOLD:    cur_q <= cur_q;
				bpsd_pkg::LVL_RESTART: cur_q <= bpsd_pkg::RESTART_LEVEL;
				bpsd_pkg::LVL_REQ:     cur_q <= req_q;
				bpsd_pkg::LVL_ZERO:    cur_q <= '0;
				default:               cur_q <= cur_q;
			endcase
		end
	end

	// event fields for the action the current step emits
	always_comb begin
		ev_down = 1'b0;
		ev_low  = '0;
		ev_high = '0;
		ev_last = 1'b1;
		case (ctrl.uw.action)
			bpsd_pkg::ACT_LOW: begin
				ev_last = 1'b1;
			end
			bpsd_pkg::ACT_OFF_HOLD: begin
				ev_low = cfg.off_hold;
			end
			bpsd_pkg::ACT_ENABLE: begin
				ev_high = cfg.enable_hold;
				ev_last = (req_q == bpsd_pkg::RESTART_LEVEL);
			end
			bpsd_pkg::ACT_STEP: begin
				ev_down = down_q;
				ev_low  = down_q ? cfg.down_low : cfg.up_low;
				ev_high = cfg.gap;
				ev_last = (cnt_q == bpsd_pkg::LVL_W'(1));
			end
			default: begin
				ev_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctrl.uw.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctrl.uw.emit) begin
			act_q   <= ctrl.uw.action;
			sdown_q <= ev_down;
			low_q   <= ev_low;
			high_q  <= ev_high;
			last_q  <= ev_last;
		end
	end

	assign st.in_fire   = in_fire;
	assign st.pwr_off   = !pwr_q;
	assign st.req_zero  = (req_q == '0);
	assign st.cur_nz    = (cur_q != '0);
	assign st.req_eq    = (req_q == cur_q);
	assign st.more      = (cnt_q != bpsd_pkg::LVL_W'(1));
	assign st.slot_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, high_q, low_q};
	assign m_tuser  = {sdown_q, act_q};
	assign m_tlast  = last_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) <= LVL_CEIL)
		else $error("stored level above ceiling");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctrl.uw.emit && ctrl.uw.action == bpsd_pkg::ACT_STEP) |-> (cnt_q != '0))
		else $error("step pulse with empty count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctrl.uw.emit) |-> (!out_valid_q || m_tready))
		else $error("result overwritten before it was taken");

endmodule

FILE: rtl/core/backlight_pulse_step_dimmer.sv
// Top level of the backlight pulse-step dimmer: register file, sequencer and datapath.
//
// Turns one brightness request word into the timed pin events that move a
// pulse-counting LED driver from the stored level to the requested one. Each
// result word is one pin event (action, direction, low and high time in ticks)
// with tlast on the final event of the request. A request with power off gives
// one plain low event; a request of zero gives one off-hold event and stores 0;
// leaving zero gives an enable event first and the driver is taken to restart
// at level 16; then one step pulse per level of difference follows. An equal
// request with a nonzero stored level gives no word at all. A small microprogram
// steps the datapath one control word per clock while no emitting step is stalled
// by an untaken word in the output register; the step-pulse loop emits one word
// per cycle while the output side keeps tready high. A new request is accepted
// only when the sequencer is back at its wait step, while the last word of the
// previous request may still sit in the output register. The user must write the
// timing registers through the APB port only while the block is idle; the block
// itself does not enforce this.
module backlight_pulse_step_dimmer #(
	parameter int unsigned MAX_LEVEL = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] level_request
	input  logic                          s_tuser,   // [0] power_on
	// pin event stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // [9:0] low_time, [19:10] high_time
	output logic [2:0]                    m_tuser,   // [1:0] pin_action, [2] step_down
	output logic                          m_tlast,   // last_event
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpsd_pkg::ADDR_W-1:0]   paddr,
	input  logic [bpsd_pkg::DATA_W-1:0]   pwdata,
	output logic [bpsd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	bpsd_pkg::cfg_t    cfg_q;
	bpsd_pkg::ctrl_t   ctrl;
	bpsd_pkg::status_t st;
	logic              wr_en;
	logic [2:0]        reg_idx;
	logic [bpsd_pkg::TICK_W-1:0] wval;
	logic [bpsd_pkg::TICK_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign wval    = pwdata[bpsd_pkg::TICK_W-1:0];

	// register writes; addresses past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_low      <= bpsd_pkg::UP_LOW_RST;
			cfg_q.down_low    <= bpsd_pkg::DOWN_LOW_RST;
			cfg_q.gap         <= bpsd_pkg::GAP_RST;
			cfg_q.off_hold    <= bpsd_pkg::OFF_HOLD_RST;
			cfg_q.enable_hold <= bpsd_pkg::ENABLE_HOLD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bpsd_pkg::REG_UP_LOW:      cfg_q.up_low      <= wval;
				bpsd_pkg::REG_DOWN_LOW:    cfg_q.down_low    <= wval;
				bpsd_pkg::REG_GAP:         cfg_q.gap         <= wval;
				bpsd_pkg::REG_OFF_HOLD:    cfg_q.off_hold    <= wval;
				bpsd_pkg::REG_ENABLE_HOLD: cfg_q.enable_hold <= wval;
				default: begin
				end
			endcase
		end
	end

	// read back; unmapped addresses read zero
	always_comb begin
		case (reg_idx)
			bpsd_pkg::REG_UP_LOW:      rd_val = cfg_q.up_low;
			bpsd_pkg::REG_DOWN_LOW:    rd_val = cfg_q.down_low;
			bpsd_pkg::REG_GAP:         rd_val = cfg_q.gap;
			bpsd_pkg::REG_OFF_HOLD:    rd_val = cfg_q.off_hold;
			bpsd_pkg::REG_ENABLE_HOLD: rd_val = cfg_q.enable_hold;
			default:                   rd_val = '0;
		endcase
	end

	assign prdata = bpsd_pkg::DATA_W'(rd_val);

	// the wait step of the microprogram is the only one that takes a request
	assign s_tready = ctrl.uw.take_input;

	bpsd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	bpsd_dpath #(
		.MAX_LEVEL (MAX_LEVEL)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.ctrl     (ctrl),
		.cfg      (cfg_q),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
